>>> design/door_lock_controller_assert.svh
// Assertion macros shared by the door lock controller modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef DOOR_LOCK_CONTROLLER_ASSERT_SVH
`define DOOR_LOCK_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define DLC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/dlc_pkg.sv
// Package for the door lock controller: codes, widths and shared structs.
// Depends on nothing; imported by every module of the block.
package dlc_pkg;

   localparam int TIMER_BITS_DEFAULT = 24;
   localparam int CFG_BITS           = 24;
   localparam int CMP_BITS           = 32;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int REQ_TDATA_BITS     = 8;
   localparam int REQ_TUSER_BITS     = 2;
   localparam int RSP_TDATA_BITS     = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_MS  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELOCK_MS    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRANT_MS     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALERT_MS     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLOSED_LEVEL = 3'd4;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RESET = 24'd50;
   localparam logic [CFG_BITS-1:0] RELOCK_MS_RESET   = 24'd1000;
   localparam logic [CFG_BITS-1:0] GRANT_MS_RESET    = 24'd60000;
   localparam logic [CFG_BITS-1:0] ALERT_MS_RESET    = 24'd60000;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_UNLOCK = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;

   typedef enum logic [1:0] {
      DOOR_UNINIT = 2'd0,
      DOOR_OPEN   = 2'd1,
      DOOR_CLOSED = 2'd2,
      DOOR_LOCKED = 2'd3
   } door_state_type;

   typedef enum logic [1:0] {
      CODE_NORMAL      = 2'd0,
      CODE_UNINIT      = 2'd1,
      CODE_FORCED_OPEN = 2'd2,
      CODE_LEFT_OPEN   = 2'd3
   } check_type;

   typedef enum logic [1:0] {
      MOTOR_NONE   = 2'd0,
      MOTOR_LOCK   = 2'd1,
      MOTOR_UNLOCK = 2'd2
   } motor_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] relock_ms;
      logic [CFG_BITS-1:0] grant_ms;
      logic [CFG_BITS-1:0] alert_ms;
      logic                closed_level;
   } cfg_type;

   typedef struct packed {
      door_state_type door_state;
      motor_type      motor_command;
      check_type      check_code;
   } result_type;

endpackage

>>> design/dlc_csr.sv
// Configuration register file of the door lock controller.
// Depends on dlc_pkg; feeds the timeout and sensor settings to dlc_fsm.
module dlc_csr
   import dlc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE_MS:  cfg_in.debounce_ms  = csr_wdata;
            REG_RELOCK_MS:    cfg_in.relock_ms    = csr_wdata;
            REG_GRANT_MS:     cfg_in.grant_ms     = csr_wdata;
            REG_ALERT_MS:     cfg_in.alert_ms     = csr_wdata;
            REG_CLOSED_LEVEL: cfg_in.closed_level = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_MS_RESET;
         cfg_ff.relock_ms    <= RELOCK_MS_RESET;
         cfg_ff.grant_ms     <= GRANT_MS_RESET;
         cfg_ff.alert_ms     <= ALERT_MS_RESET;
         cfg_ff.closed_level <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/dlc_fsm.sv
// Door state machine with debounce and unlock timers of the door lock controller.
// Depends on dlc_pkg and door_lock_controller_assert.svh; used by door_lock_controller.
`include "door_lock_controller_assert.svh"

module dlc_fsm
   import dlc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [1:0] operation,
   input  logic       sensor_level,
   input  cfg_type    cfg,
   output result_type result
);

   door_state_type        state_ff, state_in;
   logic                  prev_sensor_ff, prev_sensor_in;
   logic [TIMER_BITS-1:0] stable_ff, stable_in;
   logic [TIMER_BITS-1:0] since_ff, since_in;
   logic [TIMER_BITS-1:0] stable_inc;
   logic [TIMER_BITS-1:0] since_inc;
   door_state_type        deb;
   logic                  sensor_closed;

   assign stable_inc    = (&stable_ff) ? stable_ff : stable_ff + TIMER_BITS'(1);
   assign since_inc     = (&since_ff) ? since_ff : since_ff + TIMER_BITS'(1);
   assign sensor_closed = (sensor_level == cfg.closed_level);

   always_comb begin
      state_in             = state_ff;
      prev_sensor_in       = prev_sensor_ff;
      stable_in            = stable_ff;
      since_in             = since_ff;
      deb                  = state_ff;
      result.check_code    = CODE_NORMAL;
      result.motor_command = MOTOR_NONE;
      unique case (operation)
         OP_TICK: begin
            since_in  = since_inc;
            stable_in = stable_inc;
            if (sensor_level != prev_sensor_ff) begin
               prev_sensor_in = sensor_level;
               stable_in      = '0;
            end else if (CMP_BITS'(stable_inc) > CMP_BITS'(cfg.debounce_ms)) begin
               deb = sensor_closed ? DOOR_CLOSED : DOOR_OPEN;
            end
            unique case (state_ff)
               DOOR_UNINIT: result.check_code = CODE_UNINIT;
               DOOR_LOCKED: begin
                  if (deb == DOOR_OPEN) begin
                     result.check_code = CODE_FORCED_OPEN;
                  end
               end
               DOOR_OPEN: begin
                  if (deb == DOOR_CLOSED &&
                      CMP_BITS'(since_inc) > CMP_BITS'(cfg.relock_ms)) begin
                     result.motor_command = MOTOR_LOCK;
                     state_in             = DOOR_LOCKED;
                  end else if (deb == DOOR_OPEN &&
                               CMP_BITS'(since_inc) > CMP_BITS'(cfg.alert_ms)) begin
                     result.check_code = CODE_LEFT_OPEN;
                  end
               end
               default: begin
                  if (deb == DOOR_CLOSED &&
                      CMP_BITS'(since_inc) > CMP_BITS'(cfg.grant_ms)) begin
                     result.motor_command = MOTOR_LOCK;
                     state_in             = DOOR_LOCKED;
                  end else if (deb == DOOR_OPEN) begin
                     state_in = DOOR_OPEN;
                  end
               end
            endcase
         end
         OP_UNLOCK: begin
            if (state_ff == DOOR_UNINIT) begin
               result.check_code = CODE_UNINIT;
            end else begin
               result.motor_command = MOTOR_UNLOCK;
               since_in             = '0;
               state_in             = DOOR_CLOSED;
            end
         end
         OP_START: begin
            if (state_ff == DOOR_UNINIT) begin
               if (sensor_closed) begin
                  result.motor_command = MOTOR_LOCK;
                  state_in             = DOOR_LOCKED;
               end else begin
                  result.motor_command = MOTOR_UNLOCK;
                  since_in             = '0;
                  state_in             = DOOR_OPEN;
               end
               prev_sensor_in = sensor_level;
               stable_in      = '0;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
      result.door_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= DOOR_UNINIT;
         prev_sensor_ff <= 1'b0;
         stable_ff      <= '0;
         since_ff       <= '0;
      end else if (step_en) begin
         state_ff       <= state_in;
         prev_sensor_ff <= prev_sensor_in;
         stable_ff      <= stable_in;
         since_ff       <= since_in;
      end
   end

   `DLC_ASSERT_NEXT(a_init_sticks, clock, reset, state_ff != DOOR_UNINIT,
      state_ff != DOOR_UNINIT, "door returned to uninitialized")

endmodule

>>> design/door_lock_controller.sv
// Door lock controller top level: request register, state machine, response register.
// Depends on dlc_pkg, dlc_csr, dlc_fsm and door_lock_controller_assert.svh.
//
// Usage:
//   Requests arrive on the req_ channel: req_tuser carries the operation
//   (tick of one millisecond, unlock, start) and req_tdata the sampled
//   door sensor level. Every request transaction gives exactly one response
//   transaction on the rsp_ channel with the check code, the motor command
//   and the door state after the request.
//   Timeouts and the closed sensor level are written on the csr_ port while
//   no request is in flight; a write takes effect at the next clock edge.
//   An accepted request is held in the request register, processed by the
//   state machine into the response register and presented on rsp_.
//   Throughput: one request per cycle while the response is not stalled, set by
//   the state update between the request register and the response register.
//   Reset: the door is uninitialized, both timers and the stored sensor level
//   are zero, and the registers take their default timeouts.
//   Stall: while rsp_tready is low the response holds; the request register
//   still takes one more request, then req_tready drops until the response
//   is taken.
`include "door_lock_controller_assert.svh"

module door_lock_controller
   import dlc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // [0] sensor_level
   input  logic [REQ_TUSER_BITS-1:0] req_tuser,  // [1:0] operation
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // [1:0] check_code, [3:2] motor_command,
                                                 // [5:4] door_state
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   logic       in_valid_ff;
   logic [1:0] in_op_ff;
   logic       in_sensor_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   logic       advance;
   cfg_type    cfg;
   result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   dlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dlc_fsm #(
      .TIMER_BITS (TIMER_BITS)
   ) u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .operation    (in_op_ff),
      .sensor_level (in_sensor_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff     <= req_tuser;
         in_sensor_ff <= req_tdata[0];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_result_ff.door_state, out_result_ff.motor_command,
                        out_result_ff.check_code};

   `DLC_ASSERT_IMPLY(a_lock_means_locked, clock, reset,
      rsp_tvalid && out_result_ff.motor_command == MOTOR_LOCK,
      out_result_ff.door_state == DOOR_LOCKED, "lock command without locked state")

   `DLC_ASSERT_IMPLY(a_unlock_means_unlocked, clock, reset,
      rsp_tvalid && out_result_ff.motor_command == MOTOR_UNLOCK,
      out_result_ff.door_state == DOOR_OPEN || out_result_ff.door_state == DOOR_CLOSED,
      "unlock command without unlocked state")

   `DLC_ASSERT_IMPLY(a_forced_only_locked, clock, reset,
      rsp_tvalid && out_result_ff.check_code == CODE_FORCED_OPEN,
      out_result_ff.door_state == DOOR_LOCKED, "forced open on a door that is not locked")

   `DLC_ASSERT_IMPLY(a_uninit_code, clock, reset,
      rsp_tvalid && out_result_ff.check_code == CODE_UNINIT,
      out_result_ff.door_state == DOOR_UNINIT && out_result_ff.motor_command == MOTOR_NONE,
      "uninitialized error on an initialized door")

endmodule
